/* hdl/itk_pkg.sv */
// ============================================================================
// IMU tilt Kalman package
// Shared widths, register indexes, the arctangent table and rounding helpers.
// ============================================================================
`default_nettype none

package itk_pkg;

    localparam int IN_W      = 16;
    localparam int SMP_W     = IN_W + 1;
    localparam int ANGLE_W   = 25;
    localparam int UNC_W     = 20;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;
    localparam int AOFF_W    = 24;

    // serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;

    // serial divider: unsigned dividend and divisor
    localparam int DIV_N_W   = 54;
    localparam int DIV_D_W   = 38;

    // rounding work width
    localparam int RND_W     = 50;

    localparam logic [CFG_AW-1:0] REG_ACCEL_OFFSET_X     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ACCEL_OFFSET_Y     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ACCEL_OFFSET_Z     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GYRO_OFFSET_ROLL   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GYRO_OFFSET_PITCH  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ANGLE_OFFSET_ROLL  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_ANGLE_OFFSET_PITCH = 3'd6;
    localparam logic [CFG_AW-1:0] REG_RATE_STEP_GAIN     = 3'd7;

    localparam logic [CFG_DW-1:0] RATE_GAIN_RESET = 32'd1047553;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [UNC_W-1:0]          unc_t;

    // atan(2^-i) in radians, Q1.30
    function automatic logic [30:0] atan_entry(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            5'd24:   v = 31'd64;
            5'd25:   v = 31'd32;
            5'd26:   v = 31'd16;
            5'd27:   v = 31'd8;
            5'd28:   v = 31'd4;
            5'd29:   v = 31'd2;
            5'd30:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // shift right by s, rounding to nearest with halves away from zero
    function automatic logic signed [RND_W-1:0] round_shift(
        input logic signed [RND_W-1:0] v,
        input int unsigned             s
    );
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] half;
        logic [RND_W-1:0] t;
        mag  = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        half = RND_W'(1) << (s - 1);
        t    = (mag + half) >> s;
        return v[RND_W-1] ? -$signed(t) : $signed(t);
    endfunction

    function automatic angle_t sat_angle(input logic signed [RND_W:0] v);
        logic signed [RND_W:0] hi;
        logic signed [RND_W:0] lo;
        hi = (RND_W+1)'(16777215);
        lo = -(RND_W+1)'(16777216);
        if (v > hi) begin
            return angle_t'(hi);
        end else if (v < lo) begin
            return angle_t'(lo);
        end
        return angle_t'(v);
    endfunction

    function automatic logic [SMP_W-1:0] mag17(input logic signed [SMP_W-1:0] v);
        return v[SMP_W-1] ? SMP_W'(-v) : SMP_W'(v);
    endfunction

endpackage

`default_nettype wire

/* hdl/itk_mul.sv */
// ============================================================================
// Bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// ============================================================================
`default_nettype none

module itk_mul (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [itk_pkg::MUL_A_W-1:0]  a,
    input  wire logic        [itk_pkg::MUL_B_W-1:0]  b,
    output logic                                     done,
    output logic signed [itk_pkg::MUL_P_W-1:0]       prod
);
    import itk_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W:0]   hi_reg;
    logic [MUL_B_W-1:0]        lo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [MUL_A_W:0]   sum_next;

    always_comb begin
        sum_next = lo_reg[0] ? hi_reg + (MUL_A_W+1)'(a_reg) : hi_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // add, then shift the partial product right one place
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= {sum_next[MUL_A_W], sum_next[MUL_A_W:1]};
            lo_reg <= {sum_next[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

/* hdl/itk_div.sv */
// ============================================================================
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module itk_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [itk_pkg::DIV_N_W-1:0]  dividend,
    input  wire logic [itk_pkg::DIV_D_W-1:0]  divisor,
    output logic                              done,
    output logic [itk_pkg::DIV_N_W-1:0]       quotient
);
    import itk_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   rem_sh;
    logic               ge;
    logic [DIV_D_W:0]   rem_next;

    always_comb begin
        rem_sh   = {rem_reg, q_reg[DIV_N_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIV_N_W-2:0], ge};
            rem_reg <= rem_next[DIV_D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* hdl/imu_tilt_kalman_fusion.sv */
// ============================================================================
// IMU tilt Kalman fusion
// Roll and pitch from accelerometer tilt (root, CORDIC) blended with gyro
// rates by two scalar Kalman filters; serial multiplier and divider shared.
// ============================================================================
// Timing: the time from the accepting edge to m_valid is set by the
//          32-step serial multiplier and the 54-step serial divider.
// Requests: one at a time; the next is taken once the result is in the
//          output register, which may still be waiting.
// Reset: aresetn low clears the filter state, the registers to their
//          defaults and the handshake; no clearing pass.
`default_nettype none

module imu_tilt_kalman_fusion #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int FRACTION_BITS     = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [itk_pkg::CFG_AW-1:0]         cfg_wr_addr,
    input  wire logic [itk_pkg::CFG_DW-1:0]         cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [itk_pkg::IN_W-1:0]    s_accel_x,
    input  wire logic signed [itk_pkg::IN_W-1:0]    s_accel_y,
    input  wire logic signed [itk_pkg::IN_W-1:0]    s_accel_z,
    input  wire logic signed [itk_pkg::IN_W-1:0]    s_gyro_x,
    input  wire logic signed [itk_pkg::IN_W-1:0]    s_gyro_y,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [itk_pkg::ANGLE_W-1:0]      m_roll_estimate,
    output logic signed [itk_pkg::ANGLE_W-1:0]      m_pitch_estimate
);
    import itk_pkg::*;

    localparam int TILT_W  = FRACTION_BITS + 8;
    localparam int MEAS_W  = ((TILT_W > AOFF_W) ? TILT_W : AOFF_W) + 1;
    localparam int DIFF_W  = MEAS_W + 1;
    localparam int RATE_SH = 32 - FRACTION_BITS;
    localparam logic [DIV_D_W-1:0] ANG_DIV  = DIV_D_W'(31415) << (30 - FRACTION_BITS);
    localparam logic [DIV_D_W-1:0] HALF_DIV = ANG_DIV >> 1;
    localparam logic [MUL_B_W-1:0] DEG_SCALE = 32'd1800000;
    localparam int ROOT_W  = 27;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int CRD_W   = 40;
    localparam int Z_W     = 34;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SQ1    = 13'b0000000000010,
        ST_SQ2    = 13'b0000000000100,
        ST_SQRT   = 13'b0000000001000,
        ST_CORDIC = 13'b0000000010000,
        ST_ZMUL   = 13'b0000000100000,
        ST_ZDIV   = 13'b0000001000000,
        ST_RMUL   = 13'b0000010000000,
        ST_PRED   = 13'b0000100000000,
        ST_GDIV   = 13'b0001000000000,
        ST_UMUL   = 13'b0010000000000,
        ST_PMUL   = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [IN_W-1:0]   off_ax_reg, off_ay_reg, off_az_reg;
    logic signed [IN_W-1:0]   off_gx_reg, off_gy_reg;
    logic signed [AOFF_W-1:0] off_roll_reg, off_pitch_reg;
    logic [CFG_DW-1:0]        gain_reg;

    // sample after offsets
    logic signed [SMP_W-1:0]  ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic                     axis_reg;

    // tilt datapath
    logic [33:0]              sum_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [4:0]               sq_cnt_reg;
    logic signed [CRD_W-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [4:0]               it_reg;
    logic                     zero_reg;
    logic [DIV_N_W-1:0]       pmag_reg;
    logic                     pneg_reg;
    logic signed [MEAS_W-1:0] meas_roll_reg, meas_pitch_reg;

    // filter datapath
    logic signed [RND_W-1:0]  rs_reg;
    angle_t                   pred_reg;
    unc_t                     pp_reg;
    logic [16:0]              k_reg;
    angle_t                   roll_ang_reg, pitch_ang_reg;
    unc_t                     roll_unc_reg, pitch_unc_reg;

    // output register
    logic                     m_valid_reg;
    angle_t                   roll_out_reg, pitch_out_reg;

    // shared units
    logic                        mul_start_reg, div_start_reg;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic                        mul_done;
    logic signed [MUL_P_W-1:0]   mul_prod;
    logic [DIV_N_W-1:0]          div_n;
    logic [DIV_D_W-1:0]          div_d;
    logic                        div_done;
    logic [DIV_N_W-1:0]          div_q;

    // per-axis selections
    logic signed [SMP_W-1:0]  a_sel, num_sel, rate_sel;
    logic signed [MEAS_W-1:0] meas_sel;
    angle_t                   ang_sel;
    unc_t                     unc_sel;
    logic signed [DIFF_W-1:0] diff;

    logic                     accept;
    logic [REM_W-1:0]         rem_sh, trial;
    logic                     sq_ge;
    logic signed [CRD_W-1:0]  dx, dy;
    logic signed [Z_W-1:0]    atan_z;
    logic [20:0]              pp_sum, dnm;
    unc_t                     pp_val;
    logic [TILT_W-1:0]        tilt_mag;
    logic signed [TILT_W-1:0] tilt;
    logic signed [MEAS_W-1:0] meas_new;
    angle_t                   pred_new, ang_new;
    logic [MUL_P_W-1:0]       unc_prod;
    unc_t                     unc_new;
    logic                     out_load;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        a_sel    = axis_reg ? ay_reg : ax_reg;
        num_sel  = axis_reg ? ax_reg : ay_reg;
        rate_sel = axis_reg ? gy_reg : gx_reg;
        meas_sel = axis_reg ? meas_pitch_reg : meas_roll_reg;
        ang_sel  = axis_reg ? pitch_ang_reg : roll_ang_reg;
        unc_sel  = axis_reg ? pitch_unc_reg : roll_unc_reg;
        diff     = DIFF_W'(meas_sel) - DIFF_W'(pred_reg);
    end

    // root: two radicand bits per step
    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, root_reg, 2'b01};
        sq_ge  = rem_sh >= trial;
    end

    // CORDIC vectoring step
    always_comb begin
        dx     = y_reg >>> it_reg;
        dy     = x_reg >>> it_reg;
        atan_z = Z_W'(atan_entry(it_reg));
    end

    always_comb begin
        pp_sum   = {1'b0, unc_sel} + 21'd65536;
        pp_val   = pp_sum[20] ? {UNC_W{1'b1}} : pp_sum[UNC_W-1:0];
        dnm      = 21'(pp_reg) + 21'd589824;
        tilt_mag = div_q[TILT_W-1:0];
        if (zero_reg) begin
            tilt = '0;
        end else begin
            tilt = pneg_reg ? -$signed(tilt_mag) : $signed(tilt_mag);
        end
        if (axis_reg) begin
            meas_new = -MEAS_W'(tilt) - MEAS_W'(off_pitch_reg);
        end else begin
            meas_new = MEAS_W'(tilt) - MEAS_W'(off_roll_reg);
        end
        pred_new = sat_angle((RND_W+1)'(ang_sel) + (RND_W+1)'(rs_reg));
        ang_new  = sat_angle((RND_W+1)'(pred_reg) + (RND_W+1)'(rs_reg));
        unc_prod = MUL_P_W'(mul_prod) + MUL_P_W'(32768);
        unc_new  = unc_prod[UNC_W+15:16];
    end

    always_comb begin
        case (state_reg)
            ST_SQ1: begin
                mul_a = MUL_A_W'(mag17(a_sel));
                mul_b = MUL_B_W'(mag17(a_sel));
            end
            ST_SQ2: begin
                mul_a = MUL_A_W'(mag17(az_reg));
                mul_b = MUL_B_W'(mag17(az_reg));
            end
            ST_ZMUL: begin
                mul_a = z_reg;
                mul_b = DEG_SCALE;
            end
            ST_RMUL: begin
                mul_a = MUL_A_W'(rate_sel);
                mul_b = gain_reg;
            end
            ST_UMUL: begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'(k_reg);
            end
            ST_PMUL: begin
                mul_a = MUL_A_W'(17'd65536 - k_reg);
                mul_b = MUL_B_W'(pp_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        if (state_reg == ST_GDIV) begin
            div_n = DIV_N_W'({pp_reg, 16'd0}) + DIV_N_W'(dnm >> 1);
            div_d = DIV_D_W'(dnm);
        end else begin
            div_n = pmag_reg + DIV_N_W'(HALF_DIV);
            div_d = ANG_DIV;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SQ1;
            ST_SQ1:    if (mul_done) state_next = ST_SQ2;
            ST_SQ2:    if (mul_done) state_next = ST_SQRT;
            ST_SQRT:   if (sq_cnt_reg == 5'(ROOT_W - 1)) state_next = ST_CORDIC;
            ST_CORDIC: if (it_reg == 5'(CORDIC_ITERATIONS - 1)) state_next = ST_ZMUL;
            ST_ZMUL:   if (mul_done) state_next = ST_ZDIV;
            ST_ZDIV: begin
                if (div_done) begin
                    state_next = axis_reg ? ST_RMUL : ST_SQ1;
                end
            end
            ST_RMUL:   if (mul_done) state_next = ST_PRED;
            ST_PRED:   state_next = ST_GDIV;
            ST_GDIV:   if (div_done) state_next = ST_UMUL;
            ST_UMUL:   if (mul_done) state_next = ST_PMUL;
            ST_PMUL: begin
                if (mul_done) begin
                    state_next = axis_reg ? ST_OUT : ST_RMUL;
                end
            end
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            axis_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            roll_ang_reg  <= '0;
            pitch_ang_reg <= '0;
            roll_unc_reg  <= '0;
            pitch_unc_reg <= '0;
            off_ax_reg    <= '0;
            off_ay_reg    <= '0;
            off_az_reg    <= '0;
            off_gx_reg    <= '0;
            off_gy_reg    <= '0;
            off_roll_reg  <= '0;
            off_pitch_reg <= '0;
            gain_reg      <= RATE_GAIN_RESET;
        end else begin
            state_reg     <= state_next;
            // pulse a unit start on entry to its wait state
            mul_start_reg <= (state_next != state_reg) &&
                             ((state_next == ST_SQ1) || (state_next == ST_SQ2) ||
                              (state_next == ST_ZMUL) || (state_next == ST_RMUL) ||
                              (state_next == ST_UMUL) || (state_next == ST_PMUL));
            div_start_reg <= (state_next != state_reg) &&
                             ((state_next == ST_ZDIV) || (state_next == ST_GDIV));
            if (accept) begin
                axis_reg <= 1'b0;
            end
            if ((state_reg == ST_ZDIV) && div_done) begin
                axis_reg <= !axis_reg;
            end
            if ((state_reg == ST_PMUL) && mul_done) begin
                axis_reg <= !axis_reg;
                if (axis_reg) begin
                    pitch_ang_reg <= ang_new;
                    pitch_unc_reg <= unc_new;
                end else begin
                    roll_ang_reg <= ang_new;
                    roll_unc_reg <= unc_new;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    REG_ACCEL_OFFSET_X:     off_ax_reg    <= cfg_wr_data[IN_W-1:0];
                    REG_ACCEL_OFFSET_Y:     off_ay_reg    <= cfg_wr_data[IN_W-1:0];
                    REG_ACCEL_OFFSET_Z:     off_az_reg    <= cfg_wr_data[IN_W-1:0];
                    REG_GYRO_OFFSET_ROLL:   off_gx_reg    <= cfg_wr_data[IN_W-1:0];
                    REG_GYRO_OFFSET_PITCH:  off_gy_reg    <= cfg_wr_data[IN_W-1:0];
                    REG_ANGLE_OFFSET_ROLL:  off_roll_reg  <= cfg_wr_data[AOFF_W-1:0];
                    REG_ANGLE_OFFSET_PITCH: off_pitch_reg <= cfg_wr_data[AOFF_W-1:0];
                    REG_RATE_STEP_GAIN:     gain_reg      <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            ax_reg <= SMP_W'(s_accel_x) - SMP_W'(off_ax_reg);
            ay_reg <= SMP_W'(s_accel_y) - SMP_W'(off_ay_reg);
            az_reg <= SMP_W'(s_accel_z) - SMP_W'(off_az_reg);
            gx_reg <= SMP_W'(s_gyro_x) - SMP_W'(off_gx_reg);
            gy_reg <= SMP_W'(s_gyro_y) - SMP_W'(off_gy_reg);
        end
        case (state_reg)
            ST_SQ1: begin
                if (mul_done) sum_reg <= mul_prod[33:0];
            end
            ST_SQ2: begin
                if (mul_done) begin
                    sum_reg    <= sum_reg + mul_prod[33:0];
                    rad_reg    <= RAD_W'({sum_reg + mul_prod[33:0], 20'd0});
                    root_reg   <= '0;
                    rem_reg    <= '0;
                    sq_cnt_reg <= '0;
                end
            end
            ST_SQRT: begin
                rad_reg    <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg    <= sq_ge ? rem_sh - trial : rem_sh;
                root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 5'(ROOT_W - 1)) begin
                    x_reg    <= CRD_W'({root_reg[ROOT_W-2:0], sq_ge, 10'd0});
                    y_reg    <= CRD_W'(num_sel) <<< 20;
                    z_reg    <= '0;
                    it_reg   <= '0;
                    zero_reg <= (sum_reg == '0) && (num_sel == '0);
                end
            end
            ST_CORDIC: begin
                it_reg <= it_reg + 1'b1;
                if (!y_reg[CRD_W-1]) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_z;
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_z;
                end
            end
            ST_ZMUL: begin
                if (mul_done) begin
                    pneg_reg <= mul_prod[MUL_P_W-1];
                    pmag_reg <= mul_prod[MUL_P_W-1] ? DIV_N_W'(-mul_prod)
                                                    : DIV_N_W'(mul_prod);
                end
            end
            ST_ZDIV: begin
                if (div_done) begin
                    if (axis_reg) begin
                        meas_pitch_reg <= meas_new;
                    end else begin
                        meas_roll_reg <= meas_new;
                    end
                end
            end
            ST_RMUL: begin
                if (mul_done) rs_reg <= round_shift(RND_W'(mul_prod), RATE_SH);
            end
            ST_PRED: begin
                pred_reg <= pred_new;
                pp_reg   <= pp_val;
            end
            ST_GDIV: begin
                if (div_done) k_reg <= div_q[16:0];
            end
            ST_UMUL: begin
                if (mul_done) rs_reg <= round_shift(RND_W'(mul_prod), 16);
            end
            default: ;
        endcase
        if (out_load) begin
            roll_out_reg  <= roll_ang_reg;
            pitch_out_reg <= pitch_ang_reg;
        end
    end

    itk_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    itk_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid          = m_valid_reg;
    assign m_roll_estimate  = roll_out_reg;
    assign m_pitch_estimate = pitch_out_reg;

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_start_reg && div_start_reg))
        else $error("multiplier and divider started together");

    a_mul_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_SQ1 || state_reg == ST_SQ2 ||
                      state_reg == ST_ZMUL || state_reg == ST_RMUL ||
                      state_reg == ST_UMUL || state_reg == ST_PMUL))
        else $error("multiplier finished outside a wait state");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

/* bench/imu_tilt_kalman_fusion_tb.sv */
// ----------------------------------------------------------------------------
// IMU tilt Kalman fusion testbench
// Drives raw accelerometer and gyro samples through the fusion block.
// A scoreboard keeps its own fixed-point copy of both tilt filters.
// Each roll and pitch estimate is checked against that copy.
// Register settings change between phases, including the extremes.
// Each side of the handshake idles at random in two patterns; a third has no idling.
// ----------------------------------------------------------------------------
`default_nettype none

class tilt_fusion_scoreboard;
    longint acc_off_x, acc_off_y, acc_off_z;
    longint gyr_off_roll, gyr_off_pitch;
    longint ang_off_roll, ang_off_pitch;
    longint unsigned rate_gain;
    longint roll_ang, pitch_ang;
    longint roll_unc, pitch_unc;
    logic [24:0] roll_q[$];
    logic [24:0] pitch_q[$];
    int errors;
    longint atan_q30[16];

    function new();
        atan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                     16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                     131072, 65536, 32768};
        errors = 0;
        clear();
    endfunction

    function void clear();
        acc_off_x = 0; acc_off_y = 0; acc_off_z = 0;
        gyr_off_roll = 0; gyr_off_pitch = 0;
        ang_off_roll = 0; ang_off_pitch = 0;
        rate_gain = 1047553;
        roll_ang = 0; pitch_ang = 0; roll_unc = 0; pitch_unc = 0;
    endfunction

    function void write_reg(logic [itk_pkg::CFG_AW-1:0] idx, logic [31:0] data);
        case (idx)
            itk_pkg::REG_ACCEL_OFFSET_X:     acc_off_x = longint'($signed(data[15:0]));
            itk_pkg::REG_ACCEL_OFFSET_Y:     acc_off_y = longint'($signed(data[15:0]));
            itk_pkg::REG_ACCEL_OFFSET_Z:     acc_off_z = longint'($signed(data[15:0]));
            itk_pkg::REG_GYRO_OFFSET_ROLL:   gyr_off_roll = longint'($signed(data[15:0]));
            itk_pkg::REG_GYRO_OFFSET_PITCH:  gyr_off_pitch = longint'($signed(data[15:0]));
            itk_pkg::REG_ANGLE_OFFSET_ROLL:  ang_off_roll = longint'($signed(data[23:0]));
            itk_pkg::REG_ANGLE_OFFSET_PITCH: ang_off_pitch = longint'($signed(data[23:0]));
            itk_pkg::REG_RATE_STEP_GAIN:     rate_gain = longint'(data);
            default: ;
        endcase
    endfunction

    function longint half_away(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function longint clamp_angle(longint v);
        if (v > 16777215) begin
            return 16777215;
        end else if (v < -16777216) begin
            return -16777216;
        end
        return v;
    endfunction

    function longint unsigned int_root(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // atan(num / sqrt(a^2 + b^2)) in degrees Q.16
    function longint tilt(longint num, longint a, longint b);
        longint unsigned sum;
        longint x, y, z, dx, dy, d, p;
        sum = longint'(a * a + b * b);
        if (sum == 0 && num == 0) begin
            return 0;
        end
        x = longint'(int_root(sum << 20)) * 1024;
        y = num * 1048576;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_q30[i];
            end else begin
                x -= dx; y += dy; z -= atan_q30[i];
            end
        end
        d = longint'(31415) << 14;
        p = z * 1800000;
        if (p >= 0) begin
            return (p + d / 2) / d;
        end
        return -((-p + d / 2) / d);
    endfunction

    function void filter_axis(ref longint ang, ref longint unc, input longint rate,
                              input longint meas);
        longint pred, pp, dnm, k;
        pred = clamp_angle(ang + half_away(rate * longint'(rate_gain), 16));
        pp = unc + 65536;
        if (pp > 1048575) pp = 1048575;
        dnm = pp + (longint'(9) << 16);
        k = ((pp << 16) + dnm / 2) / dnm;
        ang = clamp_angle(pred + half_away((meas - pred) * k, 16));
        unc = ((65536 - k) * pp + 32768) >>> 16;
    endfunction

    function void note_request(logic signed [15:0] axr, logic signed [15:0] ayr,
                               logic signed [15:0] azr, logic signed [15:0] gxr,
                               logic signed [15:0] gyr);
        longint ax, ay, az, mroll, mpitch;
        ax = longint'(axr) - acc_off_x;
        ay = longint'(ayr) - acc_off_y;
        az = longint'(azr) - acc_off_z;
        mroll = tilt(ay, ax, az) - ang_off_roll;
        mpitch = -tilt(ax, ay, az) - ang_off_pitch;
        filter_axis(roll_ang, roll_unc, longint'(gxr) - gyr_off_roll, mroll);
        filter_axis(pitch_ang, pitch_unc, longint'(gyr) - gyr_off_pitch, mpitch);
        roll_q.push_back(roll_ang[24:0]);
        pitch_q.push_back(pitch_ang[24:0]);
    endfunction

    function void check_result(logic [24:0] roll, logic [24:0] pitch);
        logic [24:0] er, ep;
        if (roll_q.size() == 0) begin
            $display("%0t: unexpected result roll=%0d pitch=%0d", $realtime,
                     $signed(roll), $signed(pitch));
            errors++;
            return;
        end
        er = roll_q.pop_front();
        ep = pitch_q.pop_front();
        if (roll !== er) begin
            $display("%0t: roll mismatch expected %0d actual %0d", $realtime,
                     $signed(er), $signed(roll));
            errors++;
        end
        if (pitch !== ep) begin
            $display("%0t: pitch mismatch expected %0d actual %0d", $realtime,
                     $signed(ep), $signed(pitch));
            errors++;
        end
    endfunction
endclass

module imu_tilt_kalman_fusion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3000000;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [itk_pkg::CFG_AW-1:0] cfg_wr_addr;
    logic [itk_pkg::CFG_DW-1:0] cfg_wr_data;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [15:0] s_accel_x, s_accel_y, s_accel_z, s_gyro_x, s_gyro_y;
    logic signed [24:0] m_roll_estimate, m_pitch_estimate;

    int tx_idle_pct, rx_idle_pct;
    longint cycles = 0;
    tilt_fusion_scoreboard sb;

    imu_tilt_kalman_fusion dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_addr(cfg_wr_addr), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_gyro_x(s_gyro_x), .s_gyro_y(s_gyro_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_estimate(m_roll_estimate), .m_pitch_estimate(m_pitch_estimate)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial sb = new();

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("imu_tilt_kalman_fusion_tb: done, errors");
            $finish;
        end
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_accel_x, s_accel_y, s_accel_z, s_gyro_x, s_gyro_y);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_roll_estimate, m_pitch_estimate);
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic write_reg(logic [itk_pkg::CFG_AW-1:0] idx, logic [31:0] data);
        cfg_wr_en = 1'b1;
        cfg_wr_addr = idx;
        cfg_wr_data = data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic write_all(logic [15:0] acc, logic [15:0] gyr, logic [23:0] ang,
                             logic [31:0] gain);
        write_reg(itk_pkg::REG_ACCEL_OFFSET_X, 32'($signed(acc)));
        write_reg(itk_pkg::REG_ACCEL_OFFSET_Y, 32'($signed(acc)));
        write_reg(itk_pkg::REG_ACCEL_OFFSET_Z, 32'($signed(acc)));
        write_reg(itk_pkg::REG_GYRO_OFFSET_ROLL, 32'($signed(gyr)));
        write_reg(itk_pkg::REG_GYRO_OFFSET_PITCH, 32'($signed(gyr)));
        write_reg(itk_pkg::REG_ANGLE_OFFSET_ROLL, 32'($signed(ang)));
        write_reg(itk_pkg::REG_ANGLE_OFFSET_PITCH, 32'($signed(ang)));
        write_reg(itk_pkg::REG_RATE_STEP_GAIN, gain);
    endtask

    task automatic write_random();
        write_reg(itk_pkg::REG_ACCEL_OFFSET_X, $urandom_range(400) - 200);
        write_reg(itk_pkg::REG_ACCEL_OFFSET_Y, $urandom_range(400) - 200);
        write_reg(itk_pkg::REG_ACCEL_OFFSET_Z, $urandom);
        write_reg(itk_pkg::REG_GYRO_OFFSET_ROLL, $urandom);
        write_reg(itk_pkg::REG_GYRO_OFFSET_PITCH, $urandom_range(100) - 50);
        write_reg(itk_pkg::REG_ANGLE_OFFSET_ROLL, $urandom_range(11796480) - 5898240);
        write_reg(itk_pkg::REG_ANGLE_OFFSET_PITCH, $urandom_range(655360) - 327680);
        write_reg(itk_pkg::REG_RATE_STEP_GAIN, $urandom_range(4000000));
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] gx, logic [15:0] gy);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_accel_x = ax; s_accel_y = ay; s_accel_z = az;
        s_gyro_x = gx; s_gyro_y = gy;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random(int count);
        logic [15:0] ax, ay, az;
        for (int n = 0; n < count; n++) begin
            ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
            // mostly realistic tilt near 1 g, some full-range noise
            if ($urandom_range(3) != 0) begin
                ax = 16'($urandom_range(16000) - 8000);
                ay = 16'($urandom_range(16000) - 8000);
                az = 16'(16384 + $urandom_range(4000) - 2000);
            end
            send_sample(ax, ay, az, 16'($urandom), 16'($urandom_range(2000) - 1000));
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.roll_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_wr_addr = '0; cfg_wr_data = '0;
        s_valid = 1'b0;
        s_accel_x = '0; s_accel_y = '0; s_accel_z = '0; s_gyro_x = '0; s_gyro_y = '0;
        tx_idle_pct = 38;
        rx_idle_pct = 62;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero vector, then zero root with nonzero numerator both ways, then full-scale samples
        send_sample(0, 0, 0, 0, 0);
        send_sample(0, 16'sd1000, 0, 0, 0);
        send_sample(0, -16'sd1000, 0, 0, 0);
        send_sample(16'sd1000, 0, 0, 0, 0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 0, 16'sh8000, 16'sh7fff);
        send_sample(0, 0, 16'sh8000, 0, 0);
        send_sample(16'sh8000, 0, 0, 16'sh7fff, 16'sh8000);
        drain();

        // maximum gain with full-scale rates: drive both angles into saturation
        write_all(16'sh7fff, 16'sh8000, 24'sd5898240, 32'hffffffff);
        repeat (6) send_sample(0, 0, 0, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        drain();
        write_all(16'sh8000, 16'sh7fff, -24'sd5898240, 32'hffffffff);
        repeat (6) send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drain();

        write_random();
        send_random(220);
        drain();

        tx_idle_pct = 62;
        rx_idle_pct = 38;
        write_all(16'sh7fff, 16'sh7fff, 24'sd5898240, 32'd0);
        send_random(20);
        drain();
        write_random();
        send_random(210);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_all(16'sh8000, 16'sh8000, -24'sd5898240, 32'd1047553);
        send_random(20);
        drain();
        write_random();
        send_random(200);
        drain();

        repeat (100) @(negedge aclk);
        if (sb.errors == 0 && sb.roll_q.size() == 0) begin
            $display("imu_tilt_kalman_fusion_tb: done, clean");
        end else begin
            $display("imu_tilt_kalman_fusion_tb: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
